FILE: hw/rtl/luhn_pkg.sv
// Shared constants, types and helpers for the Luhn card number classifier.
// No dependencies; imported by card_number_luhn_classifier_core.
package luhn_pkg;

   // Input width and decimal capacity (2^54-1 has seventeen digits)
   localparam int CARD_W      = 54;
   localparam int BCD_DIGITS  = 17;
   localparam int BCD_W       = 4 * BCD_DIGITS;
   localparam int BIT_CNT_W   = $clog2(CARD_W);
   localparam int DIGIT_IDX_W = $clog2(BCD_DIGITS + 1);

   // Result field widths
   localparam int BRAND_W = 2;
   localparam int COUNT_W = 5;
   localparam int SUM_W   = 8;

   // Length window and digit constants for the brand rules
   localparam logic [COUNT_W-1:0] LEN_MIN  = COUNT_W'(13);
   localparam logic [COUNT_W-1:0] LEN_AMEX = COUNT_W'(15);
   localparam logic [COUNT_W-1:0] LEN_MAX  = COUNT_W'(16);
   localparam logic [3:0]         RADIX    = 4'd10;

   typedef enum logic [BRAND_W-1:0] {
      BRAND_INVALID    = 2'd0,
      BRAND_VISA       = 2'd1,
      BRAND_MASTERCARD = 2'd2,
      BRAND_AMEX       = 2'd3
   } brand_type;

   // Luhn contribution of one digit; doubled digits fold back below ten
   function automatic logic [3:0] luhn_weight(input logic [3:0] digit, input logic dbl);
      logic [4:0] prod;
      prod = {digit, 1'b0};
      if (!dbl) begin
         luhn_weight = digit;
      end else if (prod >= 5'd10) begin
         luhn_weight = 4'(prod - 5'd9);
      end else begin
         luhn_weight = prod[3:0];
      end
   endfunction

endpackage

FILE: hw/rtl/card_number_luhn_classifier_core.sv
// Luhn mod-10 card number classifier: bit-serial binary to BCD, then digit scan.
// Depends on luhn_pkg (widths, brand codes, luhn_weight).
//
//   channel | direction | fields                                   | handshake
//   req     | in        | card_number[53:0]                        | req_valid/req_ready
//   rsp     | out       | brand[1:0], digit_count[4:0], luhn_sum[7:0] | rsp_valid/rsp_ready
//
// Each item passes through a load step, 54 shift-and-add-3 steps (one input bit
// each), 17 digit scan steps (one BCD digit each, least significant first), and a
// step that classifies and loads the result register.
// Reset (synchronous, active high) returns to idle and drops rsp_valid.
// A result held by rsp_ready low stalls only the classify step; the next item is
// taken as soon as the result register has been loaded.
module card_number_luhn_classifier_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [luhn_pkg::CARD_W-1:0]     req_card_number,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [luhn_pkg::BRAND_W-1:0]    rsp_brand,
   output logic [luhn_pkg::COUNT_W-1:0]    rsp_digit_count,
   output logic [luhn_pkg::SUM_W-1:0]      rsp_luhn_sum
);
   import luhn_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_SCAN,
      ST_DONE
   } state_type;

   localparam logic [BIT_CNT_W-1:0]   LAST_BIT     = BIT_CNT_W'(CARD_W - 1);
   localparam logic [DIGIT_IDX_W-1:0] SCAN_END_IDX = DIGIT_IDX_W'(BCD_DIGITS - 1);

   state_type               state_ff, state_in;
   logic [CARD_W-1:0]       card_ff, card_in;
   logic [BCD_W-1:0]        bcd_ff, bcd_in;
   logic [BIT_CNT_W-1:0]    bit_cnt_ff, bit_cnt_in;
   logic [DIGIT_IDX_W-1:0]  idx_ff, idx_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [3:0]              mod_ff, mod_in;
   logic [3:0]              prev_ff, prev_in;
   logic [3:0]              lead_hi_ff, lead_hi_in;
   logic [3:0]              lead_lo_ff, lead_lo_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   brand_type               brand_ff, brand_in;
   logic [COUNT_W-1:0]      out_count_ff, out_count_in;
   logic [SUM_W-1:0]        out_sum_ff, out_sum_in;

   logic [BCD_W-1:0]        bcd_adj;
   logic [3:0]              digit;
   logic [3:0]              weight;
   logic [4:0]              mod_sum;
   brand_type               brand_calc;

   // Add three to every BCD digit of five or more before the next shift
   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   // Current scan digit and its Luhn weight
   assign digit   = bcd_ff[3:0];
   assign weight  = luhn_weight(digit, idx_ff[0]);
   assign mod_sum = {1'b0, mod_ff} + {1'b0, weight};

   // Classify from length, sum residue and leading two digits
   always_comb begin
      brand_calc = BRAND_INVALID;
      if (count_ff >= LEN_MIN && count_ff <= LEN_MAX && mod_ff == 4'd0) begin
         if ((count_ff == LEN_MIN || count_ff == LEN_MAX) && lead_hi_ff == 4'd4) begin
            brand_calc = BRAND_VISA;
         end else if (count_ff == LEN_MAX && lead_hi_ff == 4'd5 &&
                      lead_lo_ff inside {[4'd1:4'd5]}) begin
            brand_calc = BRAND_MASTERCARD;
         end else if (count_ff == LEN_AMEX && lead_hi_ff == 4'd3 &&
                      lead_lo_ff inside {4'd4, 4'd7}) begin
            brand_calc = BRAND_AMEX;
         end
      end
   end

   // Next-state and datapath
   always_comb begin
      state_in     = state_ff;
      card_in      = card_ff;
      bcd_in       = bcd_ff;
      bit_cnt_in   = bit_cnt_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      mod_in       = mod_ff;
      prev_in      = prev_ff;
      lead_hi_in   = lead_hi_ff;
      lead_lo_in   = lead_lo_ff;
      brand_in     = brand_ff;
      out_count_in = out_count_ff;
      out_sum_in   = out_sum_ff;
      rsp_valid_in = rsp_valid_ff;

      // drop the result once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               card_in    = req_card_number;
               bcd_in     = '0;
               bit_cnt_in = '0;
               state_in   = ST_CONV;
            end
         end
         ST_CONV: begin
            // shift one input bit into the BCD register
            bcd_in  = {bcd_adj[BCD_W-2:0], card_ff[CARD_W-1]};
            card_in = {card_ff[CARD_W-2:0], 1'b0};
            if (bit_cnt_ff == LAST_BIT) begin
               idx_in     = '0;
               count_in   = '0;
               sum_in     = '0;
               mod_in     = '0;
               prev_in    = '0;
               lead_hi_in = '0;
               lead_lo_in = '0;
               state_in   = ST_SCAN;
            end else begin
               bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
            end
         end
         ST_SCAN: begin
            // consume one digit, least significant first
            sum_in  = sum_ff + SUM_W'(weight);
            mod_in  = (mod_sum >= 5'(RADIX)) ? 4'(mod_sum - 5'(RADIX)) : mod_sum[3:0];
            bcd_in  = {4'd0, bcd_ff[BCD_W-1:4]};
            prev_in = digit;
            if (digit != 4'd0) begin
               count_in   = COUNT_W'(idx_ff) + COUNT_W'(1);
               lead_hi_in = digit;
               lead_lo_in = prev_ff;
            end
            if (idx_ff == SCAN_END_IDX) begin
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + DIGIT_IDX_W'(1);
            end
         end
         ST_DONE: begin
            // load the result register when it is free
            if (!rsp_valid_ff || rsp_ready) begin
               brand_in     = brand_calc;
               out_count_in = count_ff;
               out_sum_in   = sum_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state, datapath and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      card_ff      <= card_in;
      bcd_ff       <= bcd_in;
      bit_cnt_ff   <= bit_cnt_in;
      idx_ff       <= idx_in;
      count_ff     <= count_in;
      sum_ff       <= sum_in;
      mod_ff       <= mod_in;
      prev_ff      <= prev_in;
      lead_hi_ff   <= lead_hi_in;
      lead_lo_ff   <= lead_lo_in;
      brand_ff     <= brand_in;
      out_count_ff <= out_count_in;
      out_sum_ff   <= out_sum_in;
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_brand       = brand_ff;
   assign rsp_digit_count = out_count_ff;
   assign rsp_luhn_sum    = out_sum_ff;

   // Checks
   a_accept_starts_conv: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_CONV))
      else $error("accepted beat did not start conversion");

   a_bit_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV) |-> (bit_cnt_ff <= LAST_BIT))
      else $error("bit counter overran input width");

   a_mod_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_DONE) |-> (mod_ff < RADIX))
      else $error("sum residue out of range");

   a_count_behind_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (COUNT_W'(idx_ff) >= count_ff))
      else $error("digit count ahead of scan position");

   a_valid_brand_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_brand != BRAND_INVALID) |->
      (rsp_digit_count >= LEN_MIN && rsp_digit_count <= LEN_MAX))
      else $error("brand reported for out-of-range length");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for card_number_luhn_classifier_core: Luhn sum, digit
// count and brand of card numbers, checked against an in-bench classifier.
// Depends on luhn_pkg (widths, brand codes) and the core under test.
module tb;
   import luhn_pkg::*;

   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 80;
   localparam int RANDOM_CARDS   = 440;
   localparam int STEADY_CARDS   = 40;

   typedef struct packed {
      brand_type            brand;
      logic [COUNT_W-1:0]   digit_count;
      logic [SUM_W-1:0]     luhn_sum;
   } verdict_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [CARD_W-1:0]    req_card_number;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [BRAND_W-1:0]   rsp_brand;
   logic [COUNT_W-1:0]   rsp_digit_count;
   logic [SUM_W-1:0]     rsp_luhn_sum;

   verdict_type          pending_verdicts[$];
   int                   mismatch_count;
   int                   verdicts_checked;
   int                   cards_sent;
   int                   brand_hits[4];
   int                   stall_cycles;
   bit                   hold_rsp;
   bit                   steady;

   card_number_luhn_classifier_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_card_number (req_card_number),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_brand       (rsp_brand),
      .rsp_digit_count (rsp_digit_count),
      .rsp_luhn_sum    (rsp_luhn_sum)
   );

   // 10-unit clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Count digits, form the Luhn sum, then apply length and prefix rules
   function automatic verdict_type luhn_classify(input logic [CARD_W-1:0] card);
      verdict_type      r;
      longint unsigned  rest;
      longint unsigned  lead;
      int unsigned      digit;
      int unsigned      weight;
      int unsigned      count;
      int unsigned      total;
      bit               doubled;
      rest    = card;
      lead    = card;
      count   = 0;
      total   = 0;
      doubled = 1'b0;
      while (rest != 0) begin
         digit  = int'(rest % 10);
         weight = doubled ? digit * 2 : digit;
         if (weight >= 10) begin
            weight = weight - 9;
         end
         total   = total + weight;
         doubled = !doubled;
         count   = count + 1;
         rest    = rest / 10;
      end
      // keep the leading two digits
      while (lead >= 100) begin
         lead = lead / 10;
      end
      r.brand = BRAND_INVALID;
      if (count >= LEN_MIN && count <= LEN_MAX && (total % 10) == 0) begin
         if ((count == LEN_MIN || count == LEN_MAX) && lead / 10 == 4) begin
            r.brand = BRAND_VISA;
         end else if (count == LEN_MAX && lead >= 51 && lead <= 55) begin
            r.brand = BRAND_MASTERCARD;
         end else if (count == LEN_AMEX && (lead == 34 || lead == 37)) begin
            r.brand = BRAND_AMEX;
         end
      end
      r.digit_count = COUNT_W'(count);
      r.luhn_sum    = SUM_W'(total);
      return r;
   endfunction

   // Build a number from a leading value, random middle digits and a check digit
   // chosen so the Luhn test passes or fails as asked
   function automatic logic [CARD_W-1:0] build_card(input int unsigned lead,
                                                    input int unsigned lead_len,
                                                    input int unsigned total_len,
                                                    input bit pass_check);
      longint unsigned  body;
      verdict_type      v;
      int unsigned      start;
      int unsigned      d;
      body  = lead;
      start = $urandom_range(0, 9);
      for (int i = lead_len; i < total_len - 1; i++) begin
         body = body * 10 + $urandom_range(0, 9);
      end
      body       = body * 10;
      build_card = CARD_W'(body);
      for (int j = 0; j < 10; j++) begin
         d = (start + j) % 10;
         v = luhn_classify(CARD_W'(body + d));
         if (((v.luhn_sum % 10) == 0) == pass_check) begin
            build_card = CARD_W'(body + d);
            break;
         end
      end
   endfunction

   // Offer one beat, hold it until accepted, then optionally go idle
   task automatic send_card(input logic [CARD_W-1:0] card, input int unsigned gap);
      req_valid       <= 1'b1;
      req_card_number <= card;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      pending_verdicts.push_back(luhn_classify(card));
      cards_sent++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait for every outstanding verdict
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_verdicts.size() != 0) begin
         @(posedge clock);
      end
   endtask

   function automatic int unsigned random_gap;
      if (steady || $urandom_range(0, 3) != 0) begin
         return 0;
      end
      return $urandom_range(1, 5);
   endfunction

   task automatic test_corner_values;
      send_card('0, 0);
      send_card(CARD_W'(9), 0);
      send_card(CARD_W'(34), 1);
      send_card(CARD_W'(64'd9999999999999999), 0);
      send_card(CARD_W'(64'd10000000000000000), 2);
      send_card({CARD_W{1'b1}}, 0);
      drain();
   endtask

   task automatic test_brand_rules;
      // well-formed numbers of each brand
      send_card(build_card(4, 1, 13, 1'b1), 0);
      send_card(build_card(4, 1, 16, 1'b1), 0);
      send_card(build_card(51, 2, 16, 1'b1), 0);
      send_card(build_card(55, 2, 16, 1'b1), 0);
      send_card(build_card(34, 2, 15, 1'b1), 0);
      send_card(build_card(37, 2, 15, 1'b1), 0);
      // right prefix and length, bad check digit
      send_card(build_card(4, 1, 16, 1'b0), 0);
      send_card(build_card(37, 2, 15, 1'b0), 0);
      // good sum, prefix and length do not match
      send_card(build_card(4, 1, 15, 1'b1), 0);
      send_card(build_card(52, 2, 15, 1'b1), 0);
      send_card(build_card(34, 2, 16, 1'b1), 0);
      send_card(build_card(50, 2, 16, 1'b1), 0);
      send_card(build_card(56, 2, 16, 1'b1), 0);
      send_card(build_card(35, 2, 15, 1'b1), 0);
      send_card(build_card(60, 2, 16, 1'b1), 0);
      // good sum, length outside the window or used by no brand
      send_card(build_card(4, 1, 12, 1'b1), 0);
      send_card(build_card(10, 2, 17, 1'b1), 0);
      send_card(build_card(41, 2, 14, 1'b1), 0);
      drain();
   endtask

   // Stall the receiver long enough that the core backs up onto its input
   task automatic test_result_stall;
      hold_rsp = 1'b1;
      for (int i = 0; i < 6; i++) begin
         send_card(build_card(4, 1, 16, 1'b1), 0);
      end
      drain();
      hold_rsp = 1'b0;
   endtask

   task automatic random_card(output logic [CARD_W-1:0] card);
      int unsigned sel;
      int unsigned kind;
      int unsigned len;
      bit          pass;
      sel  = $urandom_range(0, 9);
      pass = $urandom_range(0, 4) != 0;
      if (sel < 5) begin
         kind = $urandom_range(0, 3);
         case (kind)
            0: begin
               card = build_card(4, 1, 13, pass);
            end
            1: begin
               card = build_card(4, 1, 16, pass);
            end
            2: begin
               card = build_card($urandom_range(51, 55), 2, 16, pass);
            end
            default: begin
               card = build_card($urandom_range(0, 1) ? 34 : 37, 2, 15, pass);
            end
         endcase
      end else if (sel < 7) begin
         len = $urandom_range(12, 17);
         if (len == 17) begin
            card = build_card($urandom_range(10, 17), 2, len, pass);
         end else begin
            card = build_card($urandom_range(10, 99), 2, len, pass);
         end
      end else if (sel < 9) begin
         card = CARD_W'({$urandom, $urandom});
      end else begin
         card = CARD_W'({$urandom, $urandom}) >> $urandom_range(0, CARD_W - 1);
      end
   endtask

   task automatic test_random_mix;
      logic [CARD_W-1:0] card;
      for (int i = 0; i < RANDOM_CARDS; i++) begin
         random_card(card);
         send_card(card, random_gap());
      end
      drain();
   endtask

   // Back-to-back beats with the receiver always ready
   task automatic test_steady_stream;
      logic [CARD_W-1:0] card;
      steady = 1'b1;
      for (int i = 0; i < STEADY_CARDS; i++) begin
         random_card(card);
         send_card(card, 0);
      end
      drain();
   endtask

   // Receiver: random stall bursts, one long hold when asked
   initial begin
      bit hold_served;
      hold_served = 1'b0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) begin
         @(posedge clock);
      end
      forever begin
         if (hold_rsp && !hold_served) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_served = 1'b1;
         end else if (!steady && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Compare each result beat with the oldest outstanding verdict
   always @(posedge clock) begin
      verdict_type exp_v;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_verdicts.size() == 0) begin
            $error("result beat with no card outstanding: brand %0d digits %0d sum %0d",
                   rsp_brand, rsp_digit_count, rsp_luhn_sum);
            mismatch_count++;
         end else begin
            exp_v = pending_verdicts.pop_front();
            verdicts_checked++;
            brand_hits[rsp_brand]++;
            if (rsp_brand !== exp_v.brand) begin
               $error("brand: expected %0d, actual %0d", exp_v.brand, rsp_brand);
               mismatch_count++;
            end
            if (rsp_digit_count !== exp_v.digit_count) begin
               $error("digit_count: expected %0d, actual %0d",
                      exp_v.digit_count, rsp_digit_count);
               mismatch_count++;
            end
            if (rsp_luhn_sum !== exp_v.luhn_sum) begin
               $error("luhn_sum: expected %0d, actual %0d", exp_v.luhn_sum, rsp_luhn_sum);
               mismatch_count++;
            end
         end
      end
   end

   // Abort when no beat moves on either side for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_card_number <= '0;
      cards_sent      = 0;
      hold_rsp        = 1'b0;
      steady          = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corner_values();
      test_brand_rules();
      test_result_stall();
      test_random_mix();
      test_steady_stream();

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("%0d card numbers sent, %0d results checked, %0d mismatches",
               cards_sent, verdicts_checked, mismatch_count);
      $display("brands seen: invalid %0d, visa %0d, mastercard %0d, amex %0d",
               brand_hits[BRAND_INVALID], brand_hits[BRAND_VISA],
               brand_hits[BRAND_MASTERCARD], brand_hits[BRAND_AMEX]);
      if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
